// File: design/rhc_pkg.sv
// shared types, constants and code table of the rtp header compressor
package rhc_pkg;

  localparam int LEN_W  = 11;
  localparam int TS_W   = 32;
  localparam int SEQ_W  = 12;
  localparam int CODE_W = 4;
  localparam int CTS_W  = 14;
  localparam int HDR_W  = 32;

  localparam int TICKS_PER_UNIT   = 160;
  localparam int MAX_PACKET_BYTES = 2048;
  localparam int MAX_W            = 17;

  localparam int HDR_FULL    = 12;
  localparam int HDR_CUT     = 8;
  localparam int FRAME_BYTES = 20;
  localparam int CODE_COUNT  = 16;

  localparam logic [1:0] VERSION_COMPACT = 2'b11;
  localparam logic [1:0] COMPACT_MARK    = 2'b11;
  localparam logic [7:0] CONTROL_TYPE    = 8'h81;

  // payload types by code index
  localparam logic [6:0] CODE_TABLE [CODE_COUNT] = '{
    7'd18, 7'd13, 7'd98, 7'd99, 7'd105, 7'd101, 7'd106, 7'd107,
    7'd127, 7'd50, 7'd110, 7'd111, 7'd112, 7'd113, 7'd114, 7'd115
  };
  localparam logic [CODE_W-1:0] CODE_FRAMED = '0;

  // reciprocal for (packet_length - 12) / FRAME_BYTES
  localparam int FR_L     = $clog2(FRAME_BYTES);
  localparam int FR_SHIFT = LEN_W + FR_L;
  localparam int FR_MW    = LEN_W + 1;
  localparam int FR_PW    = FR_SHIFT + LEN_W;
  localparam logic [63:0] FR_M64 =
    ((64'd1 << FR_SHIFT) + 64'(FRAME_BYTES) - 64'd1) / 64'(FRAME_BYTES);
  localparam logic [FR_MW-1:0] FR_M = FR_M64[FR_MW-1:0];

  // reciprocal for timestamp delta / TICKS_PER_UNIT, split in two halves
  localparam int DIV_L     = $clog2(TICKS_PER_UNIT);
  localparam int DIV_SHIFT = TS_W + DIV_L;
  localparam int DIV_LO_W  = 16;
  localparam int DIV_HI_W  = TS_W + 1 - DIV_LO_W;
  localparam int DIV_PW    = 2 * TS_W + 1;
  localparam logic [63:0] DIV_M64 =
    ((64'd1 << DIV_SHIFT) + 64'(TICKS_PER_UNIT) - 64'd1) / 64'(TICKS_PER_UNIT);
  localparam logic [DIV_LO_W-1:0] DIV_M_LO = DIV_M64[DIV_LO_W-1:0];
  localparam logic [DIV_HI_W-1:0] DIV_M_HI = DIV_M64[TS_W:DIV_LO_W];

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    ST_CONV = 2'd0,
    ST_PASS = 2'd1,
    ST_DROP = 2'd2
  } rhc_status_t;

  typedef struct packed {
    rhc_status_t        status;
    logic [CODE_W-1:0]  code;
    logic [SEQ_W-1:0]   seq_inc;
    logic [TS_W-1:0]    ts;
    logic [LEN_W-1:0]   new_len;
  } rhc_cmd_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [Q_AW:0]  count;
  } rhc_qstat_t;

endpackage

// File: design/rhc_front.sv
// header classification: pass, drop or convert, code lookup, sequence step
module rhc_front import rhc_pkg::*; (
  input  logic [7:0]       first_byte,
  input  logic [7:0]       type_byte,
  input  logic [TS_W-1:0]  timestamp,
  input  logic [LEN_W-1:0] packet_length,
  output rhc_cmd_t         cmd
);

  logic              hit;
  logic [CODE_W-1:0] idx;
  logic [LEN_W-1:0]  body_len;
  logic [FR_PW-1:0]  fr_prod;
  logic [LEN_W-1:0]  frames;
  logic              bad_len;

  always_comb begin
    hit = 1'b0;
    idx = '0;
    // highest index first so the lowest match wins
    for (int i = CODE_COUNT - 1; i >= 0; i--) begin
      if (type_byte[6:0] == CODE_TABLE[i]) begin
        hit = 1'b1;
        idx = CODE_W'(i);
      end
    end
  end

  assign body_len = packet_length - LEN_W'(HDR_FULL);
  assign fr_prod  = FR_PW'(body_len) * FR_PW'(FR_M);
  assign frames   = fr_prod[FR_SHIFT +: LEN_W];
  assign bad_len  = (packet_length < LEN_W'(HDR_FULL)) ||
                    ({{(MAX_W-LEN_W){1'b0}}, packet_length} >= MAX_W'(MAX_PACKET_BYTES));

  always_comb begin
    cmd.code    = idx;
    cmd.ts      = timestamp;
    cmd.seq_inc = (idx == CODE_FRAMED) ? SEQ_W'(frames) : SEQ_W'(1);
    if (first_byte[7:6] == VERSION_COMPACT) begin
      cmd.status  = ST_PASS;
      cmd.new_len = packet_length;
    end else if (bad_len || type_byte == CONTROL_TYPE || !hit) begin
      cmd.status  = ST_DROP;
      cmd.new_len = '0;
    end else begin
      cmd.status  = ST_CONV;
      cmd.new_len = packet_length - LEN_W'(HDR_CUT);
    end
  end

endmodule

// File: design/rhc_queue.sv
// short command queue between classifier and converter
module rhc_queue import rhc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rhc_cmd_t   push_cmd,
  input  logic       pop,
  output rhc_cmd_t   head_cmd,
  output rhc_qstat_t stat
);

  rhc_cmd_t        entry_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign stat.count = count_r;
  assign stat.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// File: design/rhc_back.sv
// converter: timestamp base and sequence state, scaled delta, compact header
module rhc_back import rhc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  rhc_cmd_t          q_cmd,
  output logic              q_pop,
  input  logic              out_ready,
  output logic              out_valid,
  output rhc_status_t       out_status,
  output logic [HDR_W-1:0]  out_header,
  output logic [CTS_W-1:0]  out_cts,
  output logic [LEN_W-1:0]  out_len
);

  logic              advance;
  logic              started_r, started_nxt;
  logic [TS_W-1:0]   base_r, base_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [TS_W-1:0]   diff_nxt;

  logic              s1_v_r;
  rhc_status_t       s1_status_r;
  logic [CODE_W-1:0] s1_code_r;
  logic [SEQ_W-1:0]  s1_seq_r;
  logic [TS_W-1:0]   s1_diff_r;
  logic [LEN_W-1:0]  s1_len_r;

  logic                       s2_v_r;
  rhc_status_t                s2_status_r;
  logic [CODE_W-1:0]          s2_code_r;
  logic [SEQ_W-1:0]           s2_seq_r;
  logic [LEN_W-1:0]           s2_len_r;
  logic [TS_W+DIV_LO_W-1:0]   s2_plo_r;
  logic [TS_W+DIV_HI_W-1:0]   s2_phi_r;

  logic [DIV_PW-1:0] prod_full;
  logic [CTS_W-1:0]  cts;

  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && q_valid;

  always_comb begin
    started_nxt = started_r;
    base_nxt    = base_r;
    seq_nxt     = seq_r;
    diff_nxt    = '0;
    if (q_pop && q_cmd.status == ST_CONV) begin
      started_nxt = 1'b1;
      seq_nxt     = seq_r + q_cmd.seq_inc;
      if (started_r && q_cmd.ts > base_r) begin
        diff_nxt = q_cmd.ts - base_r;
      end else begin
        base_nxt = q_cmd.ts;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      base_r    <= '0;
      seq_r     <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      started_r <= started_nxt;
      base_r    <= base_nxt;
      seq_r     <= seq_nxt;
      if (advance) begin
        s1_v_r    <= q_valid;
        s2_v_r    <= s1_v_r;
        out_valid <= s2_v_r;
      end
    end
  end

  assign prod_full = DIV_PW'(s2_plo_r) + (DIV_PW'(s2_phi_r) << DIV_LO_W);
  assign cts       = prod_full[DIV_SHIFT +: CTS_W];

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_status_r <= q_cmd.status;
      s1_code_r   <= q_cmd.code;
      s1_seq_r    <= seq_r;
      s1_diff_r   <= diff_nxt;
      s1_len_r    <= q_cmd.new_len;

      s2_status_r <= s1_status_r;
      s2_code_r   <= s1_code_r;
      s2_seq_r    <= s1_seq_r;
      s2_len_r    <= s1_len_r;
      s2_plo_r    <= (TS_W+DIV_LO_W)'(s1_diff_r) * (TS_W+DIV_LO_W)'(DIV_M_LO);
      s2_phi_r    <= (TS_W+DIV_HI_W)'(s1_diff_r) * (TS_W+DIV_HI_W)'(DIV_M_HI);

      out_status  <= s2_status_r;
      out_len     <= s2_len_r;
      if (s2_status_r == ST_CONV) begin
        out_header <= {COMPACT_MARK, s2_code_r, s2_seq_r, cts};
        out_cts    <= cts;
      end else begin
        out_header <= '0;
        out_cts    <= '0;
      end
    end
  end

endmodule

// File: design/rtp_header_compressor.sv
// top level of the rtp header compressor
//
// usage:
//  - input stream: one beat per packet header (first byte, type byte,
//    timestamp, packet length); accepted when in_tvalid and in_tready are high
//  - output stream: one beat per input beat, in order; out_tuser carries the
//    status (converted, pass through, dropped), out_tdata the compact header,
//    the scaled timestamp and the new length
//  - path: an accepted beat passes through the queue, the s1 and s2 registers
//    and the output register; older queued beats and receiver stalls delay it
//  - throughput: one beat per cycle while out_tready is high; the timestamp
//    base compare and update plus the sequence add are combinational; the
//    tick-constant divide is a reciprocal multiply over the two following stages
//  - reset: synchronous, active low; clears the queue, the pipeline valids,
//    the started flag, the timestamp base and the local sequence number
//  - stall: while out_tvalid is high and out_tready low the converter pipeline
//    holds; the classifier keeps accepting beats until the four-entry queue
//    fills, then in_tready drops
module rtp_header_compressor import rhc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // first_byte[7:0], type_byte[15:8], timestamp[47:16], packet_length[58:48]
  input  logic [63:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // compact_header[31:0], compressed_ts[45:32], new_length[56:46]
  output logic [63:0] out_tdata,
  // status[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready
);

  rhc_cmd_t    front_cmd;
  rhc_cmd_t    head_cmd;
  rhc_qstat_t  q_stat;
  logic        in_beat;
  logic        q_pop;
  rhc_status_t res_status;
  logic [HDR_W-1:0] res_header;
  logic [CTS_W-1:0] res_cts;
  logic [LEN_W-1:0] res_len;

  // classify straight off the input beat
  rhc_front u_front (
    .first_byte    (in_tdata[7:0]),
    .type_byte     (in_tdata[15:8]),
    .timestamp     (in_tdata[47:16]),
    .packet_length (in_tdata[58:48]),
    .cmd           (front_cmd)
  );

  assign in_tready = !q_stat.full;
  assign in_beat   = in_tvalid && in_tready;

  // decouples classifier from converter
  rhc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_beat),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // stateful conversion and output register
  rhc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_stat.empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (res_status),
    .out_header (res_header),
    .out_cts    (res_cts),
    .out_len    (res_len)
  );

  assign out_tuser = res_status;
  assign out_tdata = {7'd0, res_len, res_cts, res_header};

  // queue occupancy never goes past its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count past depth");

  // anything not converted carries an all-zero header and timestamp
  a_zero_unconverted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_CONV |-> out_tdata[45:0] == '0)
    else $error("header on unconverted beat");

  // dropped beats carry zero length
  a_drop_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_DROP |-> out_tdata[56:46] == '0)
    else $error("length on dropped beat");

  // converted header has the mark and embeds the scaled timestamp
  a_conv_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_CONV |->
      out_tdata[31:30] == COMPACT_MARK && out_tdata[13:0] == out_tdata[45:32])
    else $error("malformed compact header");

endmodule

// File: bench/rhc_compact_checker.sv
// header compression checker: predicts every compact header beat and compares it
module rhc_compact_checker import rhc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] in_tdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  output int          error_count,
  output int          pending_count,
  output int          converted_count,
  output int          passed_count,
  output int          dropped_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    rhc_status_t       status;
    logic [HDR_W-1:0]  header;
    logic [CTS_W-1:0]  cts;
    logic [LEN_W-1:0]  new_len;
  } compact_beat_t;

  compact_beat_t     pending_headers[$];
  logic              seen_first;
  logic [TS_W-1:0]   ts_base;
  logic [SEQ_W-1:0]  next_seq;
  int                mismatches;

  // advances the compressor state by one packet header and returns its beat
  function automatic compact_beat_t compress_header(input logic [7:0] fb, input logic [7:0] tb,
                                                    input logic [TS_W-1:0] ts,
                                                    input logic [LEN_W-1:0] len);
    compact_beat_t    r;
    int               code;
    logic [TS_W-1:0]  delta;
    logic [SEQ_W-1:0] seq;
    r.status  = ST_DROP;
    r.header  = '0;
    r.cts     = '0;
    r.new_len = '0;
    code      = -1;
    delta     = '0;
    if (fb[7:6] == VERSION_COMPACT) begin
      r.status  = ST_PASS;
      r.new_len = len;
      return r;
    end
    if (int'(len) < HDR_FULL || int'(len) >= MAX_PACKET_BYTES || tb == CONTROL_TYPE) begin
      return r;
    end
    for (int i = 0; i < CODE_COUNT; i++) begin
      if (code < 0 && CODE_TABLE[i] == tb[6:0]) code = i;
    end
    if (code < 0) return r;
    if (!seen_first) begin
      ts_base    = ts;
      seen_first = 1'b1;
    end else if (ts > ts_base) begin
      delta = (ts - ts_base) / TS_W'(TICKS_PER_UNIT);
    end else begin
      ts_base = ts;
    end
    seq       = next_seq;
    r.cts     = delta[CTS_W-1:0];
    r.header  = {COMPACT_MARK, CODE_W'(code), seq, r.cts};
    if (CODE_W'(code) == CODE_FRAMED) begin
      next_seq = seq + SEQ_W'((int'(len) - HDR_FULL) / FRAME_BYTES);
    end else begin
      next_seq = seq + 1'b1;
    end
    r.status  = ST_CONV;
    r.new_len = len - LEN_W'(HDR_CUT);
    return r;
  endfunction

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    compact_beat_t want;
    if (!rst_n) begin
      seen_first = 1'b0;
      ts_base    = '0;
      next_seq   = '0;
      mismatches = 0;
      pending_headers.delete();
      converted_count <= 0;
      passed_count    <= 0;
      dropped_count   <= 0;
    end else begin
      // output side first, so a beat never matches an item taken in the same cycle
      if (out_tvalid && out_tready) begin
        if (pending_headers.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got status %0d data 0x%0h",
                   $time, out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = pending_headers.pop_front();
          report_field("status", want.status, out_tuser);
          report_field("compact_header", want.header, out_tdata[31:0]);
          report_field("compressed_ts", want.cts, out_tdata[45:32]);
          report_field("new_length", want.new_len, out_tdata[56:46]);
          case (want.status)
            ST_CONV: converted_count <= converted_count + 1;
            ST_PASS: passed_count    <= passed_count + 1;
            default: dropped_count   <= dropped_count + 1;
          endcase
        end
      end
      if (in_tvalid && in_tready) begin
        pending_headers.push_back(compress_header(in_tdata[7:0], in_tdata[15:8],
                                                  in_tdata[47:16], in_tdata[58:48]));
      end
    end
    error_count   <= mismatches;
    pending_count <= pending_headers.size();
  end

endmodule

// File: bench/rtp_header_compressor_tb.sv
// testbench top of the rtp header compressor: stimulus, flow control and verdict
module rtp_header_compressor_tb import rhc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;   // quiet cycles before giving up
  localparam int HOLD_OFF_LEN   = 40;     // long receiver stall, fills the queue
  localparam int PHASE_ITEMS    = 285;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [63:0] in_tdata   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;

  int error_count, pending_count, converted_count, passed_count, dropped_count;

  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  logic        hold_off_request   = 1'b0;
  logic        hold_off_done      = 1'b0;
  int          hold_off_left      = 0;
  int          quiet_cycles       = 0;
  int          input_stall_cycles = 0;
  logic [31:0] stream_ts          = 32'd5000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rtp_header_compressor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  rhc_compact_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .error_count     (error_count),
    .pending_count   (pending_count),
    .converted_count (converted_count),
    .passed_count    (passed_count),
    .dropped_count   (dropped_count)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_off_request && !hold_off_done) begin
      hold_off_done = 1'b1;
      hold_off_left = HOLD_OFF_LEN;
    end
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog: ends the run when neither channel moves a beat for too long
  always @(posedge clk) begin
    if (in_tvalid && !in_tready) input_stall_cycles <= input_stall_cycles + 1;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < WATCHDOG_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_count);
      $display("FAIL");
      $finish;
    end
  end

  // offers one header beat, with random idle cycles ahead of it, and waits for it
  // to be taken; valid stays high when the next beat follows directly
  task automatic send_packet(input logic [7:0] fb, input logic [7:0] tb,
                             input logic [31:0] ts, input logic [10:0] len);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {5'b0, len, ts, tb, fb};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // mostly convertible headers over a running timestamp, with pass-through,
  // drop cases and raw noise mixed in
  task automatic random_packet(output logic [7:0] fb, output logic [7:0] tb,
                               output logic [31:0] ts, output logic [10:0] len);
    int       pick;
    int       code;
    logic [6:0] pt;
    logic     known;
    pick = $urandom_range(99);
    code = $urandom_range(CODE_COUNT - 1);
    fb   = {2'($urandom_range(2)), 6'($urandom)};
    tb   = {1'($urandom), CODE_TABLE[code]};
    len  = 11'($urandom_range(HDR_FULL, 400));
    if ($urandom_range(9) == 0) len = 11'($urandom_range(HDR_FULL, 2047));
    case ($urandom_range(19))
      0:       stream_ts = stream_ts - 32'($urandom_range(0, 3_000_000)); // not rising
      1:       stream_ts = $urandom;
      2:       stream_ts = stream_ts + 32'($urandom_range(2_700_000, 50_000_000));
      default: stream_ts = stream_ts + 32'($urandom_range(0, 4000));
    endcase
    ts = stream_ts;
    if (pick < 70) begin
      // well-formed header, keep as built
    end else if (pick < 82) begin
      fb[7:6] = VERSION_COMPACT;
      tb      = 8'($urandom);
      len     = 11'($urandom);
    end else if (pick < 86) begin
      len = 11'($urandom_range(0, HDR_FULL - 1));
    end else if (pick < 89) begin
      tb = CONTROL_TYPE;
    end else if (pick < 94) begin
      // payload type outside the code table
      do begin
        pt    = 7'($urandom);
        known = 1'b0;
        for (int i = 0; i < CODE_COUNT; i++) begin
          if (CODE_TABLE[i] == pt) known = 1'b1;
        end
      end while (known);
      tb = {1'($urandom), pt};
    end else begin
      fb  = 8'($urandom);
      tb  = 8'($urandom);
      ts  = $urandom;
      len = 11'($urandom);
    end
  endtask

  task automatic run_random(input int count);
    logic [7:0]  fb, tb;
    logic [31:0] ts;
    logic [10:0] len;
    repeat (count) begin
      random_packet(fb, tb, ts, len);
      send_packet(fb, tb, ts, len);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every code index once, rising timestamps, marker bit toggling;
    // the framed code takes the largest length so the sequence jumps
    for (int i = 0; i < CODE_COUNT; i++) begin
      send_packet({2'(i % 3), 6'(i)}, {1'(i), CODE_TABLE[i]}, 32'(1000 + i * 487),
                  (i == 0) ? 11'd2047 : 11'(HDR_FULL + 20 * i));
    end
    send_packet(8'h00, 8'h92, 32'd9000, 11'd11);            // one byte short of a header
    send_packet(8'h3f, 8'h12, 32'd9000, 11'd0);             // empty packet
    send_packet(8'hff, CONTROL_TYPE, 32'd0, 11'd0);         // compact already, length ignored
    send_packet(8'hc0, 8'h12, 32'hffff_ffff, 11'd2047);     // compact already, longest
    send_packet(8'h80, CONTROL_TYPE, 32'd9000, 11'd100);    // control packet
    send_packet(8'h80, 8'h01, 32'd9000, 11'd100);           // payload type not in table
    send_packet(8'h40, 8'h8d, 32'd1000, 11'd40);            // timestamp equal to base
    send_packet(8'h40, 8'h0d, 32'd500, 11'd40);             // timestamp falls, base reloads
    send_packet(8'h80, 8'h7f, 32'hffff_ffff, 11'd200);      // huge delta, truncated to 14 bits
    send_packet(8'h00, 8'h12, 32'd0, 11'd12);               // wraps to zero, framed, no frames
    send_packet(8'h00, 8'h92, 32'd0, 11'd31);               // equal to reloaded base

    // back to back, with one long receiver hold-off so the queue fills
    hold_off_request = 1'b1;
    run_random(PHASE_ITEMS);

    sender_idle_pct = 76;
    run_random(PHASE_ITEMS);

    sender_idle_pct    = 0;
    receiver_stall_pct = 76;
    run_random(PHASE_ITEMS);

    sender_idle_pct    = 8;
    receiver_stall_pct = 8;
    run_random(PHASE_ITEMS);

    // drain: the checker's registered pending count already accounts for the last beat
    in_tvalid          <= 1'b0;
    receiver_stall_pct = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d header beats: %0d converted, %0d passed through, %0d dropped",
             converted_count + passed_count + dropped_count, converted_count,
             passed_count, dropped_count);
    $display("input held back by a full block for %0d cycles, %0d mismatches",
             input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/rhc_pkg.sv
design/rhc_front.sv
design/rhc_queue.sv
design/rhc_back.sv
design/rtp_header_compressor.sv
bench/rhc_compact_checker.sv
bench/rtp_header_compressor_tb.sv
